>>> rtl/tkq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tkq_pkg - shared types and constants for the timed key event playback queue
// Queue geometry, field widths, field codes and the controller state type.
// ----------------------------------------------------------------------------
package tkq_pkg;

  localparam int QUEUE_DEPTH = 32;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam int EVLEN_W = 16;
  localparam int TWITCH_W = 12;
  localparam int HMARK_W  = 6;
  localparam int LMARK_W  = 5;
  localparam int LEN_W    = EVLEN_W + TWITCH_W;  // scaled duration, exact
  localparam int TIME_W   = 32;
  localparam int CFG_W    = 12;
  localparam int CFG_IDX_W = 2;
  localparam int CMP_W    = (CNT_W > HMARK_W) ? CNT_W : HMARK_W;

  // opcodes
  localparam logic OP_ENQUEUE = 1'b0;
  localparam logic OP_TICK    = 1'b1;

  // input modes
  localparam logic [1:0] MODE_PDL_NORM = 2'd0;
  localparam logic [1:0] MODE_PDL_REV  = 2'd1;
  localparam logic [1:0] MODE_REMOTE   = 2'd2;

  // key actions
  localparam logic [1:0] KEY_NONE  = 2'd0;
  localparam logic [1:0] KEY_PRESS = 2'd1;
  localparam logic [1:0] KEY_UP    = 2'd2;

  // flow actions
  localparam logic [1:0] FLOW_NONE = 2'd0;
  localparam logic [1:0] FLOW_XOFF = 2'd1;
  localparam logic [1:0] FLOW_XON  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TWITCH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HMARK  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LMARK  = 2'd2;

  localparam logic [TWITCH_W-1:0] TWITCH_RST = 12'd60;
  localparam logic [HMARK_W-1:0]  HMARK_RST  = 6'd24;
  localparam logic [LMARK_W-1:0]  LMARK_RST  = 5'd8;

  typedef logic [PTR_W-1:0] ptr_t;

  typedef struct packed {
    logic             down;
    logic [LEN_W-1:0] len;
  } entry_t;

  typedef struct packed {
    logic   rd_en;
    ptr_t   rd_addr;
    logic   wr_en;
    ptr_t   wr_addr;
    entry_t wr_data;
  } store_req_t;

  typedef struct packed {
    logic [TWITCH_W-1:0] twitch_length;
    logic [HMARK_W-1:0]  high_mark;
    logic [LMARK_W-1:0]  low_mark;
  } cfg_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

endpackage
`default_nettype wire

>>> rtl/timed_key_event_playback_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// timed_key_event_playback_queue - keying event queue with XON/XOFF marks
// Buffers remote key events and plays them out against a running time base.
//
// Input: an item (enqueue or tick) transfers on a clock edge with start high
// and busy low. Output: one result per item, shown for a single cycle with
// out_valid high; the receiver takes it unconditionally.
// Config: cfg_we writes cfg_wdata to register cfg_index (0 twitch length,
// 1 high mark, 2 low mark, 3 ignored) at once; write only while idle.
// Timing: the accept cycle reads the queue head from the event RAM and forms
// the scaled duration; the next cycle updates the queue (busy high); the
// result appears the cycle after. No new item is taken while the update runs,
// as the RAM read must come ahead of the update.
// Reset (synchronous, rst_n low): queue empty, not paused, transition time
// zero, registers to 60/24/8. RAM contents are not cleared; only written
// entries are ever used.
// ----------------------------------------------------------------------------
module timed_key_event_playback_queue (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          in_op,
  input  wire logic                          in_key_is_down,
  input  wire logic [tkq_pkg::EVLEN_W-1:0]   in_event_length,
  input  wire logic [tkq_pkg::TIME_W-1:0]    in_time_now,
  input  wire logic [1:0]                    in_mode_in,
  input  wire logic [1:0]                    in_paddle_mode,
  output logic                               out_valid,
  output logic [1:0]                         out_mode_out,
  output logic [1:0]                         out_key_action,
  output logic [1:0]                         out_flow_action,
  output logic [tkq_pkg::CNT_W-1:0]          out_queue_level,
  input  wire logic                          cfg_we,
  input  wire logic [tkq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [tkq_pkg::CFG_W-1:0]     cfg_wdata
);
  import tkq_pkg::*;

  cfg_t       cfg_r;
  store_req_t store_req;
  entry_t     store_rd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.twitch_length <= TWITCH_RST;
      cfg_r.high_mark     <= HMARK_RST;
      cfg_r.low_mark      <= LMARK_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TWITCH: cfg_r.twitch_length <= cfg_wdata[TWITCH_W-1:0];
        CFG_HMARK:  cfg_r.high_mark     <= cfg_wdata[HMARK_W-1:0];
        CFG_LMARK:  cfg_r.low_mark      <= cfg_wdata[LMARK_W-1:0];
        default: ;
      endcase
    end
  end

  tkq_store u_store (
    .clk     (clk),
    .req     (store_req),
    .rd_data (store_rd)
  );

  tkq_core u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .start           (start),
    .busy            (busy),
    .in_op           (in_op),
    .in_key_is_down  (in_key_is_down),
    .in_event_length (in_event_length),
    .in_time_now     (in_time_now),
    .in_mode_in      (in_mode_in),
    .in_paddle_mode  (in_paddle_mode),
    .store_req       (store_req),
    .store_rd        (store_rd),
    .out_valid       (out_valid),
    .out_mode_out    (out_mode_out),
    .out_key_action  (out_key_action),
    .out_flow_action (out_flow_action),
    .out_queue_level (out_queue_level)
  );

endmodule
`default_nettype wire

>>> rtl/tkq_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tkq_store - event storage
// Single-port-write, single-port-read synchronous RAM, registered read data.
// ----------------------------------------------------------------------------
module tkq_store (
  input  wire logic                clk,
  input  wire tkq_pkg::store_req_t req,
  output tkq_pkg::entry_t          rd_data
);
  import tkq_pkg::*;

  entry_t mem [QUEUE_DEPTH];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

>>> rtl/tkq_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tkq_core - queue controller
// Holds pointers, count, flow state and transition time; reads the head entry
// on accept and updates the queue in the following cycle.
// ----------------------------------------------------------------------------
module tkq_core (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire tkq_pkg::cfg_t               cfg,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic                        in_op,
  input  wire logic                        in_key_is_down,
  input  wire logic [tkq_pkg::EVLEN_W-1:0] in_event_length,
  input  wire logic [tkq_pkg::TIME_W-1:0]  in_time_now,
  input  wire logic [1:0]                  in_mode_in,
  input  wire logic [1:0]                  in_paddle_mode,
  output tkq_pkg::store_req_t              store_req,
  input  wire tkq_pkg::entry_t             store_rd,
  output logic                             out_valid,
  output logic [1:0]                       out_mode_out,
  output logic [1:0]                       out_key_action,
  output logic [1:0]                       out_flow_action,
  output logic [tkq_pkg::CNT_W-1:0]        out_queue_level
);
  import tkq_pkg::*;

  state_t state_r, state_nxt;
  logic   accept;

  // latched item
  logic              op_r, kdown_r;
  logic [TIME_W-1:0] now_r;
  logic [1:0]        mode_r, paddles_r;
  logic [LEN_W-1:0]  prod_r;

  // queue state
  ptr_t              head_r, head_nxt, tail_r, tail_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              paused_r, paused_nxt;
  logic [TIME_W-1:0] ntt_r, ntt_nxt;

  // results
  logic              out_valid_r;
  logic [1:0]        mode_res_r, key_res_r, flow_res_r;
  logic [1:0]        mode_res, key_res, flow_res;
  logic              wr_en;

  // scratch
  logic [CNT_W-1:0]  count_inc, count_dec;
  logic [TIME_W-1:0] ntt_eff;
  logic [1:0]        mode_eff;

  assign accept = start && !busy;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_EXEC;
      ST_EXEC: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    busy = 1'b0;
    case (state_r)
      ST_IDLE: busy = 1'b0;
      ST_EXEC: busy = 1'b1;
      default: busy = 1'b0;
    endcase
  end

  // queue update, evaluated in the execute cycle
  always_comb begin
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    count_nxt  = count_r;
    paused_nxt = paused_r;
    ntt_nxt    = ntt_r;
    mode_res   = mode_r;
    key_res    = KEY_NONE;
    flow_res   = FLOW_NONE;
    wr_en      = 1'b0;
    count_inc  = count_r + CNT_W'(1);
    count_dec  = count_r - CNT_W'(1);
    ntt_eff    = ntt_r;
    mode_eff   = mode_r;

    if (op_r == OP_ENQUEUE) begin
      if (count_r < CNT_W'(QUEUE_DEPTH)) begin
        wr_en     = 1'b1;
        tail_nxt  = (tail_r == ptr_t'(QUEUE_DEPTH - 1)) ? '0 : tail_r + ptr_t'(1);
        count_nxt = count_inc;
        if (!paused_r && CMP_W'(cfg.high_mark) == CMP_W'(count_inc)) begin
          paused_nxt = 1'b1;
          flow_res   = FLOW_XOFF;
        end
      end
    end else begin
      if ((mode_r == MODE_PDL_NORM || mode_r == MODE_PDL_REV) &&
          count_r != '0) begin
        mode_eff = MODE_REMOTE;
        ntt_eff  = '0;
      end
      mode_res = mode_eff;
      ntt_nxt  = ntt_eff;
      if (mode_eff == MODE_REMOTE && ntt_eff < now_r) begin
        if (count_r != '0) begin
          ntt_nxt   = now_r + TIME_W'(store_rd.len);
          key_res   = store_rd.down ? KEY_PRESS : KEY_UP;
          count_nxt = count_dec;
          head_nxt  = (head_r == ptr_t'(QUEUE_DEPTH - 1)) ? '0 : head_r + ptr_t'(1);
          if (paused_r && CMP_W'(cfg.low_mark) == CMP_W'(count_dec)) begin
            paused_nxt = 1'b0;
            flow_res   = FLOW_XON;
          end
        end else begin
          // queue ran dry: release the key, hand back to the paddles
          key_res  = KEY_UP;
          mode_res = paddles_r;
        end
      end
    end
  end

  // head is read on accept; the last write was made in an earlier execute cycle
  always_comb begin
    store_req.rd_en   = accept;
    store_req.rd_addr = head_r;
    store_req.wr_en   = (state_r == ST_EXEC) && wr_en;
    store_req.wr_addr = tail_r;
    store_req.wr_data = '{down: kdown_r, len: prod_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      paused_r    <= 1'b0;
      ntt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == ST_EXEC);
      if (state_r == ST_EXEC) begin
        head_r   <= head_nxt;
        tail_r   <= tail_nxt;
        count_r  <= count_nxt;
        paused_r <= paused_nxt;
        ntt_r    <= ntt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r      <= in_op;
      kdown_r   <= in_key_is_down;
      now_r     <= in_time_now;
      mode_r    <= in_mode_in;
      paddles_r <= in_paddle_mode;
      prod_r    <= LEN_W'(in_event_length) * LEN_W'(cfg.twitch_length);
    end
    if (state_r == ST_EXEC) begin
      mode_res_r <= mode_res;
      key_res_r  <= key_res;
      flow_res_r <= flow_res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_mode_out    = mode_res_r;
  assign out_key_action  = key_res_r;
  assign out_flow_action = flow_res_r;
  assign out_queue_level = count_r;

endmodule
`default_nettype wire
